// ===== sv/fqei_pkg.sv =====
// Package for the four-quadrant elevation interpolator.
// Holds widths, codes and the shared control struct; no dependencies.
`default_nettype none
package fqei_pkg;
   localparam int MaxSites  = 64;
   localparam int IdxW      = 6;
   localparam int LatW      = 28;
   localparam int LonW      = 29;
   localparam int ElevW     = 17;
   localparam int CountW    = 7;
   localparam int NumW      = 48;
   localparam int DenW      = 31;

   localparam logic       OP_LOAD   = 1'b0;
   localparam logic       OP_QUERY  = 1'b1;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;
   localparam logic [1:0] CSR_SITES = 2'd0;

   // One quadrant's kept site.
   typedef struct packed {
      logic                    ok;
      logic signed [LatW-1:0]  lat;
      logic signed [LonW-1:0]  lon;
      logic        [ElevW-1:0] elev;
   } site_type;

   // Control travelling from the sequencer to the divider.
   typedef struct packed {
      logic                   start;
      logic [NumW-1:0]        num;
      logic [DenW-1:0]        den;
   } div_ctl_type;
endpackage
`default_nettype wire

// ===== sv/fqei_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on fqei_pkg.
`default_nettype none
interface fqei_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [fqei_pkg::IdxW-1:0]            site_index;
   logic signed [fqei_pkg::LatW-1:0]     point_lat;
   logic signed [fqei_pkg::LonW-1:0]     point_lon;
   logic [fqei_pkg::ElevW-1:0]           site_elevation;
   modport source (output valid, operation, site_index, point_lat, point_lon,
      site_elevation, input ready);
   modport sink (input valid, operation, site_index, point_lat, point_lon,
      site_elevation, output ready);
endinterface

interface fqei_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [fqei_pkg::ElevW-1:0] elevation;
   logic [1:0]                 status;
   modport source (output valid, elevation, status, input ready);
   modport sink (input valid, elevation, status, output ready);
endinterface
`default_nettype wire

// ===== sv/fqei_cell.sv =====
// One quadrant cell: keeps the best site of its quadrant as sites stream past.
// Depends on fqei_pkg.
`default_nettype none
module fqei_cell (
   input  wire logic                              clock,
   input  wire logic                              clear,
   input  wire logic                              shift_en,
   input  wire logic                              upper,
   input  wire logic                              east,
   input  wire logic signed [fqei_pkg::LatW-1:0]  q_lat,
   input  wire logic signed [fqei_pkg::LonW-1:0]  q_lon,
   input  wire fqei_pkg::site_type                site_in,
   output fqei_pkg::site_type                     site_out,
   output fqei_pkg::site_type                     best
);
   fqei_pkg::site_type pass_ff, best_ff, best_in;
   logic in_q, better;

   always_comb begin
      in_q = site_in.ok
         && (upper ? (q_lat <= site_in.lat) : (site_in.lat <= q_lat))
         && (east ? (q_lon < site_in.lon) : (site_in.lon <= q_lon));
      better = (upper ? (site_in.lat <= best_ff.lat) : (best_ff.lat <= site_in.lat))
         && (east ? (site_in.lon <= best_ff.lon) : (best_ff.lon <= site_in.lon));
      best_in = best_ff;
      if (in_q && (!best_ff.ok || better)) begin
         best_in = site_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         best_ff.ok <= 1'b0;
         pass_ff.ok <= 1'b0;
      end else if (shift_en) begin
         best_ff <= best_in;
         pass_ff <= site_in;
      end
   end

   assign site_out = pass_ff;
   assign best     = best_ff;
endmodule
`default_nettype wire

// ===== sv/fqei_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on fqei_pkg.
`default_nettype none
module fqei_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fqei_pkg::div_ctl_type       ctl,
   output logic                             busy,
   output logic [fqei_pkg::NumW-1:0]        quot
);
   localparam int CntW = $clog2(fqei_pkg::NumW + 1);
   logic [fqei_pkg::NumW-1:0] q_ff, q_in;
   logic [fqei_pkg::DenW:0]   r_ff, r_in, trial;
   logic [fqei_pkg::DenW-1:0] d_ff;
   logic [CntW-1:0]           cnt_ff, cnt_in;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[fqei_pkg::DenW-1:0], q_ff[fqei_pkg::NumW-1]};
      if (ctl.start) begin
         q_in = ctl.num;
         r_in = '0;
         cnt_in = CntW'(fqei_pkg::NumW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[fqei_pkg::NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[fqei_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (ctl.start) begin
         d_ff <= ctl.den;
      end
   end

   assign busy = ctl.start || (cnt_ff != '0);
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== sv/four_quadrant_elevation_interpolator.sv =====
// A load request writes one site. A query streams the sites in use out of the
// site memory, one a cycle, through a row of four quadrant cells, then runs up
// to three divisions on one shared divider.
// Depends on fqei_pkg, fqei_if, fqei_cell and fqei_div.
`default_nettype none
module four_quadrant_elevation_interpolator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   fqei_req_if.sink                              req,
   fqei_rsp_if.source                            rsp,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [1:0]                       csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_SCAN = 8'b00000010, S_SIDE = 8'b00000100,
      S_SDIV = 8'b00001000, S_SEL  = 8'b00010000, S_GDIV = 8'b00100000,
      S_FIN  = 8'b01000000, S_OUT  = 8'b10000000
   } state_type;

   localparam int LatW = fqei_pkg::LatW;
   localparam int LonW = fqei_pkg::LonW;
   localparam int ElevW = fqei_pkg::ElevW;
   localparam int NumW = fqei_pkg::NumW;
   localparam logic [1:0] CSR_ADDR = {fqei_pkg::CSR_SITES[0], 1'b0} << 1;

   state_type state_ff, state_in;
   logic [fqei_pkg::CountW-1:0] sites_ff;
   logic [fqei_pkg::CountW-1:0] rd_ff;
   logic                        rd_valid_ff;
   logic signed [LatW-1:0]  lat_mem [fqei_pkg::MaxSites];
   logic signed [LonW-1:0]  lon_mem [fqei_pkg::MaxSites];
   logic [ElevW-1:0]        elev_mem [fqei_pkg::MaxSites];
   fqei_pkg::site_type      rd_site_ff;
   fqei_pkg::site_type      chain [5];
   fqei_pkg::site_type      best [4];
   logic signed [LatW-1:0]  q_lat_ff;
   logic signed [LonW-1:0]  q_lon_ff;
   logic [2:0]              drain_ff;
   logic                    side_ff;
   logic                    clear;
   logic [ElevW-1:0]        e_elev_ff, f_elev_ff, out_elev_ff;
   logic signed [LatW-1:0]  e_lat_ff, f_lat_ff;
   logic                    e_ok_ff, f_ok_ff;
   logic [1:0]              out_st_ff;
   fqei_pkg::div_ctl_type   dctl;
   logic                    dbusy;
   logic [NumW-1:0]         dquot;
   logic [ElevW-1:0]        lo_elev_ff, hi_elev_ff;
   logic                    use_div_ff;
   logic signed [NumW:0]    num_ff;
   logic [fqei_pkg::DenW-1:0] den_ff;
   logic signed [LonW+1:0]  dl_ff, dh_ff;
   logic [1:0]              phase_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR) ? 32'(sites_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sites_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR) begin
         sites_ff <= csr_pwdata[fqei_pkg::CountW-1:0];
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp.valid;
   assign clear = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.operation == fqei_pkg::OP_LOAD) begin
         lat_mem[req.site_index]  <= req.point_lat;
         lon_mem[req.site_index]  <= req.point_lon;
         elev_mem[req.site_index] <= req.site_elevation;
      end
      rd_site_ff.lat  <= lat_mem[rd_ff[fqei_pkg::IdxW-1:0]];
      rd_site_ff.lon  <= lon_mem[rd_ff[fqei_pkg::IdxW-1:0]];
      rd_site_ff.elev <= elev_mem[rd_ff[fqei_pkg::IdxW-1:0]];
   end

   logic [fqei_pkg::CountW-1:0] n_sat;
   assign n_sat = (sites_ff > fqei_pkg::CountW'(fqei_pkg::MaxSites))
      ? fqei_pkg::CountW'(fqei_pkg::MaxSites) : sites_ff;

   assign chain[0].ok   = rd_valid_ff;
   assign chain[0].lat  = rd_site_ff.lat;
   assign chain[0].lon  = rd_site_ff.lon;
   assign chain[0].elev = rd_site_ff.elev;

   for (genvar g = 0; g < 4; g++) begin : g_cell
      fqei_cell u_cell (
         .clock(clock), .clear(clear), .shift_en(state_ff == S_SCAN),
         .upper(g < 2), .east((g % 2) == 1), .q_lat(q_lat_ff), .q_lon(q_lon_ff),
         .site_in(chain[g]), .site_out(chain[g+1]), .best(best[g]));
   end

   // Side interpolation operands: lo is the west site, hi the east site.
   fqei_pkg::site_type lo_s, hi_s;
   assign lo_s = side_ff ? best[2] : best[0];
   assign hi_s = side_ff ? best[3] : best[1];

   logic signed [NumW+1:0] sum_w;
   assign sum_w = (NumW+2)'(dh_ff) * $signed({1'b0, lo_elev_ff})
      + (NumW+2)'(dl_ff) * $signed({1'b0, hi_elev_ff});

   always_comb begin
      dctl.start = 1'b0;
      dctl.num   = num_ff[NumW-1:0];
      dctl.den   = den_ff;
      if ((state_ff == S_SDIV || state_ff == S_GDIV) && phase_ff == 2'd2 && use_div_ff) begin
         dctl.start = 1'b1;
      end
   end

   fqei_div u_div (.clock(clock), .reset(reset), .ctl(dctl), .busy(dbusy), .quot(dquot));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) begin
            state_in = (req.operation == fqei_pkg::OP_QUERY && n_sat != '0) ? S_SCAN : S_OUT;
         end
         S_SCAN: if (drain_ff == 3'd5) state_in = S_SIDE;
         S_SIDE: state_in = S_SDIV;
         S_SDIV: if (phase_ff == 2'd3 && !dbusy) state_in = side_ff ? S_SEL : S_SIDE;
         S_SEL:  state_in = S_GDIV;
         S_GDIV: if (phase_ff == 2'd3 && !dbusy) state_in = S_FIN;
         S_FIN:  state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT) begin
            rsp.valid <= 1'b1;
         end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
         end
      end
   end

   logic [ElevW-1:0] side_elev;
   logic signed [LatW:0] dlat_e, dlat_f;
   assign side_elev = use_div_ff ? dquot[ElevW-1:0] : lo_elev_ff;
   assign dlat_e = (LatW+1)'(e_lat_ff) - (LatW+1)'(q_lat_ff);
   assign dlat_f = (LatW+1)'(q_lat_ff) - (LatW+1)'(f_lat_ff);

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            q_lat_ff <= req.point_lat;
            q_lon_ff <= req.point_lon;
            rd_ff <= '0;
            rd_valid_ff <= 1'b0;
            drain_ff <= '0;
            side_ff <= 1'b0;
            out_elev_ff <= '0;
            out_st_ff <= (req.operation == fqei_pkg::OP_QUERY) ? fqei_pkg::ST_EMPTY
               : fqei_pkg::ST_OK;
         end
         S_SCAN: begin
            if (rd_ff < n_sat) begin
               rd_ff <= rd_ff + 1'b1;
               rd_valid_ff <= 1'b1;
            end else begin
               rd_valid_ff <= 1'b0;
               drain_ff <= drain_ff + 1'b1;
            end
         end
         S_SIDE: begin
            phase_ff <= '0;
            lo_elev_ff <= lo_s.ok ? lo_s.elev : hi_s.elev;
            hi_elev_ff <= hi_s.elev;
            use_div_ff <= lo_s.ok && hi_s.ok;
            dl_ff <= (LonW+2)'(q_lon_ff) - (LonW+2)'(lo_s.lon);
            dh_ff <= (LonW+2)'(hi_s.lon) - (LonW+2)'(q_lon_ff);
            den_ff <= fqei_pkg::DenW'((LonW+2)'(hi_s.lon) - (LonW+2)'(lo_s.lon));
            if (side_ff) begin
               f_ok_ff <= lo_s.ok || hi_s.ok;
               f_lat_ff <= lo_s.ok ? lo_s.lat : hi_s.lat;
            end else begin
               e_ok_ff <= lo_s.ok || hi_s.ok;
               e_lat_ff <= lo_s.ok ? lo_s.lat : hi_s.lat;
            end
         end
         S_SDIV, S_GDIV: begin
            if (phase_ff == 2'd0) begin
               num_ff <= (NumW+1)'(sum_w);
               phase_ff <= 2'd1;
            end else if (phase_ff == 2'd1) begin
               // Negative numerator or empty span keeps the fallback value.
               if (num_ff < 0 || $signed(den_ff) <= 0) use_div_ff <= 1'b0;
               phase_ff <= 2'd2;
            end else if (phase_ff == 2'd2) begin
               phase_ff <= 2'd3;
            end else if (!dbusy && state_ff == S_SDIV) begin
               if (side_ff) f_elev_ff <= side_elev;
               else e_elev_ff <= side_elev;
               side_ff <= 1'b1;
            end else if (!dbusy) begin
               out_elev_ff <= side_elev;
               out_st_ff <= fqei_pkg::ST_OK;
            end
         end
         S_SEL: begin
            phase_ff <= '0;
            // G reuses the side datapath: lo weight is dlat_e on F, hi is dlat_f on E.
            dh_ff <= (LonW+2)'(dlat_e);
            dl_ff <= (LonW+2)'(dlat_f);
            lo_elev_ff <= f_ok_ff ? f_elev_ff : e_elev_ff;
            hi_elev_ff <= e_elev_ff;
            den_ff <= fqei_pkg::DenW'((LatW+1)'(e_lat_ff) - (LatW+1)'(f_lat_ff));
            use_div_ff <= e_ok_ff && f_ok_ff && (e_lat_ff > f_lat_ff);
         end
         S_FIN: begin
            if (!e_ok_ff && !f_ok_ff) begin
               out_elev_ff <= '0;
               out_st_ff <= fqei_pkg::ST_NONE;
            end
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT) begin
         rsp.elevation <= out_elev_ff;
         rsp.status <= out_st_ff;
      end
   end
endmodule
`default_nettype wire

// ===== sv/fqei_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
// Depends on fqei_pkg and the top level's ports.
`default_nettype none
module fqei_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_operation,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [fqei_pkg::ElevW-1:0] rsp_elevation
);
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fqei_pkg::ST_OK |-> rsp_elevation == '0)
      else $error("nonzero elevation with fault status");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == fqei_pkg::OP_QUERY |=> !req_ready)
      else $error("accepted during query");
endmodule

bind four_quadrant_elevation_interpolator fqei_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .req_operation(req.operation), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_elevation(rsp.elevation));
`default_nettype wire

// ===== tb/four_quadrant_elevation_interpolator_tb.sv =====
// Self-checking testbench for the four-quadrant elevation interpolator.
// Loads site tables, queries points and checks each result against its own
// predictor. Depends on fqei_pkg, fqei_if and the block itself.
`default_nettype none
module four_quadrant_elevation_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MaxSites = fqei_pkg::MaxSites;
   localparam int IdxW     = fqei_pkg::IdxW;
   localparam int LatW     = fqei_pkg::LatW;
   localparam int LonW     = fqei_pkg::LonW;
   localparam int ElevW    = fqei_pkg::ElevW;
   localparam logic       OP_LOAD   = fqei_pkg::OP_LOAD;
   localparam logic       OP_QUERY  = fqei_pkg::OP_QUERY;
   localparam logic [1:0] ST_OK     = fqei_pkg::ST_OK;
   localparam logic [1:0] ST_EMPTY  = fqei_pkg::ST_EMPTY;
   localparam logic [1:0] ST_NONE   = fqei_pkg::ST_NONE;
   localparam logic [1:0] CSR_SITES = fqei_pkg::CSR_SITES;

   localparam int CycleLimit = 2000000;
   localparam int DrainWait  = 260;
   localparam int TargetReqs = 700;

   typedef struct {
      logic [ElevW-1:0] elevation;
      logic [1:0]       status;
   } answer_type;

   logic clock;
   logic reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   fqei_req_if req ();
   fqei_rsp_if rsp ();

   four_quadrant_elevation_interpolator dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   longint     site_lat [MaxSites];
   longint     site_lon [MaxSites];
   longint     site_elev [MaxSites];
   int         scan_count;
   answer_type pending_answers [$];
   int         mismatches;
   int         cycles;
   int         sent_requests;
   bit         steady;
   int         hold_token;
   int         hold_seen;
   int         hold_left;
   int         stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold when a test asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready  <= 1'b0;
         hold_seen  <= 0;
         hold_left  <= 0;
         stall_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready  <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 2);
         rsp.ready  <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: elevation %0d status %0d",
                  rsp.elevation, rsp.status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp.elevation !== want.elevation || rsp.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected elevation %0d status %0d, got %0d %0d",
                     want.elevation, want.status, rsp.elevation, rsp.status);
            end
         end
      end
   end

   function automatic longint side_elevation(int lo, int hi, longint q_lon);
      longint den, num;
      den = site_lon[hi] - site_lon[lo];
      num = (site_lon[hi] - q_lon) * site_elev[lo] + (q_lon - site_lon[lo]) * site_elev[hi];
      if (den <= 0 || num < 0)
         return site_elev[lo];
      return num / den;
   endfunction

   function automatic answer_type interpolate(logic op, logic [IdxW-1:0] idx,
         logic signed [LatW-1:0] lat, logic signed [LonW-1:0] lon,
         logic [ElevW-1:0] elev);
      answer_type ans;
      longint q_lat, q_lon, la, lo, e_elev, e_lat, f_elev, f_lat, g, num;
      int n, a, b, c, d;
      bit e_ok, f_ok;
      ans.elevation = '0;
      ans.status = ST_OK;
      q_lat = lat;
      q_lon = lon;
      if (op == OP_LOAD) begin
         site_lat[idx] = q_lat;
         site_lon[idx] = q_lon;
         site_elev[idx] = elev;
         return ans;
      end
      n = (scan_count > MaxSites) ? MaxSites : scan_count;
      if (n == 0) begin
         ans.status = ST_EMPTY;
         return ans;
      end
      a = -1; b = -1; c = -1; d = -1;
      for (int i = 0; i < n; i++) begin
         la = site_lat[i];
         lo = site_lon[i];
         if (q_lat <= la && lo <= q_lon &&
               (a < 0 || (la <= site_lat[a] && site_lon[a] <= lo))) a = i;
         if (q_lat <= la && q_lon < lo &&
               (b < 0 || (la <= site_lat[b] && lo <= site_lon[b]))) b = i;
         if (la <= q_lat && lo <= q_lon &&
               (c < 0 || (site_lat[c] <= la && site_lon[c] <= lo))) c = i;
         if (la <= q_lat && q_lon < lo &&
               (d < 0 || (site_lat[d] <= la && lo <= site_lon[d]))) d = i;
      end
      e_ok = 1'b1; f_ok = 1'b1; e_elev = 0; e_lat = 0; f_elev = 0; f_lat = 0;
      if (a >= 0 && b >= 0) begin
         e_elev = side_elevation(a, b, q_lon); e_lat = site_lat[a];
      end else if (a >= 0) begin
         e_elev = site_elev[a]; e_lat = site_lat[a];
      end else if (b >= 0) begin
         e_elev = site_elev[b]; e_lat = site_lat[b];
      end else begin
         e_ok = 1'b0;
      end
      if (c >= 0 && d >= 0) begin
         f_elev = side_elevation(c, d, q_lon); f_lat = site_lat[c];
      end else if (c >= 0) begin
         f_elev = site_elev[c]; f_lat = site_lat[c];
      end else if (d >= 0) begin
         f_elev = site_elev[d]; f_lat = site_lat[d];
      end else begin
         f_ok = 1'b0;
      end
      if (!e_ok && !f_ok) begin
         ans.status = ST_NONE;
         return ans;
      end
      if (!e_ok) begin
         g = f_elev;
      end else if (!f_ok) begin
         g = e_elev;
      end else if (e_lat > f_lat) begin
         num = (e_lat - q_lat) * f_elev + (q_lat - f_lat) * e_elev;
         g = (num < 0) ? f_elev : num / (e_lat - f_lat);
      end else begin
         g = f_elev;
      end
      if (g < 0)
         g = 0;
      ans.elevation = g[ElevW-1:0];
      return ans;
   endfunction

   task automatic send_request(logic op, int idx, longint lat, longint lon, int elev);
      int r, gap;
      answer_type ans;
      r = $urandom_range(0, 99);
      gap = steady ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.operation      <= op;
      req.site_index     <= idx[IdxW-1:0];
      req.point_lat      <= lat[LatW-1:0];
      req.point_lon      <= lon[LonW-1:0];
      req.site_elevation <= elev[ElevW-1:0];
      do @(posedge clock); while (!req.ready);
      ans = interpolate(op, idx[IdxW-1:0], lat[LatW-1:0], lon[LonW-1:0], elev[ElevW-1:0]);
      pending_answers.insert(pending_answers.size(), ans);
      sent_requests++;
   endtask

   task automatic drain;
      req.valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_scan_count(int value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_SITES;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      scan_count = value & 32'h7F;
   endtask

   function automatic longint clip(longint v, longint lim);
      return (v > lim) ? lim : (v < -lim) ? -lim : v;
   endfunction

   task automatic test_empty_table;
      send_request(OP_QUERY, 0, 0, 0, 0);
      send_request(OP_QUERY, 63, -90000000, 180000000, 131071);
   endtask

   task automatic test_extremes;
      send_request(OP_LOAD, 0, 90000000, -180000000, 90000);
      send_request(OP_LOAD, 1, 90000000, 180000000, 0);
      send_request(OP_LOAD, 2, -90000000, -180000000, 65535);
      send_request(OP_LOAD, 3, -90000000, 180000000, 1);
      send_request(OP_LOAD, 63, 1000, 1000, 12345);
      write_scan_count(4);
      send_request(OP_QUERY, 0, 0, 0, 0);
      send_request(OP_QUERY, 0, 90000000, 180000000, 0);
      send_request(OP_QUERY, 0, -90000000, -180000000, 0);
      send_request(OP_QUERY, 0, 45000000, -179999999, 0);
      send_request(OP_QUERY, 0, -1, 1, 0);
      write_scan_count(1);
      send_request(OP_QUERY, 0, -5, 5, 0);
      send_request(OP_QUERY, 0, 90000000, -180000000, 0);
   endtask

   task automatic test_one_side_cases;
      send_request(OP_LOAD, 0, 100, 100, 500);
      send_request(OP_LOAD, 1, 100, 300, 900);
      send_request(OP_LOAD, 2, 200, 200, 700);
      write_scan_count(3);
      send_request(OP_QUERY, 0, 50, 200, 0);
      send_request(OP_QUERY, 0, 100, 200, 0);
      send_request(OP_QUERY, 0, 300, 200, 0);
      send_request(OP_QUERY, 0, 150, 250, 0);
      send_request(OP_QUERY, 0, 150, 50, 0);
   endtask

   task automatic test_random_layouts;
      int layout, k, n, queries, spread;
      longint c_lat, c_lon;
      layout = 0;
      while (sent_requests < TargetReqs) begin
         k = (layout % 6 == 0) ? MaxSites : $urandom_range(1, 12);
         spread = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50)
                                              : $urandom_range(100, 3000000);
         c_lat = longint'($urandom_range(0, 180000000)) - 90000000;
         c_lon = longint'($urandom_range(0, 360000000)) - 180000000;
         steady = (layout % 5 == 3);
         for (int i = 0; i < k; i++)
            send_request(OP_LOAD, i,
               clip(c_lat + $urandom_range(0, 2 * spread) - spread, 90000000),
               clip(c_lon + $urandom_range(0, 2 * spread) - spread, 180000000),
               ($urandom_range(0, 7) == 0) ? 90000 : $urandom_range(0, 90000));
         if (k == MaxSites)
            n = (layout % 12 == 0) ? 127 : ($urandom_range(0, 1) ? MaxSites : 65);
         else
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, k) : k;
         write_scan_count(n);
         if (layout == 1)
            hold_token++;
         queries = $urandom_range(10, 30);
         for (int q = 0; q < queries; q++) begin
            if (layout == 2 && q == queries / 2)
               drain();
            case ($urandom_range(0, 19))
               0, 1: send_request(OP_LOAD, $urandom_range(0, k - 1),
                  clip(c_lat + $urandom_range(0, 2 * spread) - spread, 90000000),
                  clip(c_lon + $urandom_range(0, 2 * spread) - spread, 180000000),
                  $urandom_range(0, 90000));
               2: send_request(OP_QUERY, $urandom_range(0, 63),
                  $urandom_range(0, 180000000) - 90000000,
                  $urandom_range(0, 360000000) - 180000000, $urandom_range(0, 131071));
               default: send_request(OP_QUERY, $urandom_range(0, 63),
                  clip(c_lat + $urandom_range(0, 2 * spread) - spread, 90000000),
                  clip(c_lon + $urandom_range(0, 2 * spread) - spread, 180000000),
                  $urandom_range(0, 131071));
            endcase
         end
         layout++;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      cycles = 0;
      mismatches = 0;
      sent_requests = 0;
      scan_count = 0;
      steady = 1'b0;
      hold_token = 0;
      req.valid = 1'b0;
      req.operation = OP_LOAD;
      req.site_index = '0;
      req.point_lat = '0;
      req.point_lon = '0;
      req.site_elevation = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_SITES;
      csr_pwdata = '0;
      for (int i = 0; i < MaxSites; i++) begin
         site_lat[i] = 0;
         site_lon[i] = 0;
         site_elev[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_extremes();
      test_one_side_cases();
      test_random_layouts();
      write_scan_count(0);
      send_request(OP_QUERY, 0, 0, 0, 0);
      drain();
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
sv/fqei_pkg.sv
sv/fqei_if.sv
sv/fqei_cell.sv
sv/fqei_div.sv
sv/four_quadrant_elevation_interpolator.sv
sv/fqei_checker.sv
tb/four_quadrant_elevation_interpolator_tb.sv
